>>> hdl/cbp_pkg.sv
package cbp_pkg;

    localparam int CODE_W         = 32;
    localparam int MAX_CODE_WIDTH = 32;
    localparam int EFF_MAX_WIDTH  = (MAX_CODE_WIDTH < CODE_W) ? MAX_CODE_WIDTH : CODE_W;
    localparam int WIDTH_W        = 6;
    localparam int BYTES_PER_CODE = 4;
    localparam int MERGE_W        = 8 + CODE_W;

    localparam logic [WIDTH_W-1:0] RESET_CODE_WIDTH = WIDTH_W'(8);
    localparam logic [7:0]         END_MARKER       = 8'd42;

    typedef enum logic
    {
        CMD_PACK = 1'b0,
        CMD_END  = 1'b1
    } cbp_cmd_t;

    typedef struct packed
    {
        logic [BYTES_PER_CODE-1:0][7:0] bytes;
        logic [2:0]                     count;
        logic                           is_end;
    } cbp_entry_t;

    typedef struct packed
    {
        logic       valid;
        cbp_entry_t entry;
    } cbp_slot_t;

endpackage

>>> hdl/cbp_ifs.sv
interface cbp_cfg_if;
    import cbp_pkg::*;
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] code_width;
    modport source (output valid, output code_width, input ready);
    modport sink (input valid, input code_width, output ready);
endinterface

interface cbp_in_if;
    import cbp_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [CODE_W-1:0] code_value;
    modport source (output valid, output command, output code_value, input ready);
    modport sink (input valid, input command, input code_value, output ready);
endinterface

interface cbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;
    modport source (output valid, output out_byte, output last_of_run, output stream_end,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input stream_end,
                  output ready);
endinterface

>>> hdl/cbp_front.sv
module cbp_front
    import cbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cbp_cfg_if.sink   cfg,
    cbp_in_if.sink    codes,
    output cbp_slot_t push,
    input  logic      push_ready
);

    logic [WIDTH_W-1:0] code_width_reg;
    logic [7:0]         partial_reg;
    logic [7:0]         partial_next;
    logic [2:0]         filled_reg;
    logic [2:0]         filled_next;

    logic [WIDTH_W-1:0] width_eff;
    logic [CODE_W:0]    mask_wide;
    logic [CODE_W-1:0]  masked;
    logic [WIDTH_W-1:0] total;
    logic [WIDTH_W-1:0] shift;
    logic [MERGE_W-1:0] merged;
    logic [2:0]         nbytes;
    logic               accept;
    logic               is_end;

    assign cfg.ready   = 1'b1;
    assign codes.ready = push_ready;
    assign accept      = codes.valid && push_ready;
    assign is_end      = (codes.command == CMD_END);

    always_comb
    begin
        if (code_width_reg > WIDTH_W'(EFF_MAX_WIDTH))
        begin
            width_eff = WIDTH_W'(EFF_MAX_WIDTH);
        end
        else
        begin
            width_eff = code_width_reg;
        end
        mask_wide = ((CODE_W+1)'(1) << width_eff) - (CODE_W+1)'(1);
        masked    = codes.code_value & mask_wide[CODE_W-1:0];
        total     = WIDTH_W'(filled_reg) + width_eff;
        shift     = WIDTH_W'(MERGE_W) - total;
        merged    = {partial_reg, {CODE_W{1'b0}}} | ({8'd0, masked} << shift);
        nbytes    = total[5:3];
    end

    always_comb
    begin
        push.valid        = accept && (is_end || nbytes != 3'd0);
        push.entry.bytes  = '0;
        push.entry.count  = nbytes;
        push.entry.is_end = is_end;
        partial_next      = partial_reg;
        filled_next       = filled_reg;
        if (is_end)
        begin
            if (filled_reg != 3'd0)
            begin
                push.entry.bytes[0] = partial_reg;
                push.entry.bytes[1] = END_MARKER;
                push.entry.count    = 3'd2;
            end
            else
            begin
                push.entry.bytes[0] = END_MARKER;
                push.entry.count    = 3'd1;
            end
            if (accept)
            begin
                partial_next = 8'd0;
                filled_next  = 3'd0;
            end
        end
        else
        begin
            for (int i = 0; i < BYTES_PER_CODE; i++)
            begin
                push.entry.bytes[i] = merged[MERGE_W-1-8*i -: 8];
            end
            if (accept)
            begin
                filled_next = total[2:0];
                unique case (nbytes)
                    3'd0:    partial_next = merged[39:32];
                    3'd1:    partial_next = merged[31:24];
                    3'd2:    partial_next = merged[23:16];
                    3'd3:    partial_next = merged[15:8];
                    default: partial_next = merged[7:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_width_reg <= RESET_CODE_WIDTH;
            partial_reg    <= 8'd0;
            filled_reg     <= 3'd0;
        end
        else
        begin
            if (cfg.valid)
            begin
                code_width_reg <= cfg.code_width;
            end
            partial_reg <= partial_next;
            filled_reg  <= filled_next;
        end
    end

endmodule

>>> hdl/cbp_queue.sv
module cbp_queue
    import cbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cbp_slot_t push,
    output logic      push_ready,
    output cbp_slot_t head,
    input  logic      pop
);

    cbp_entry_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/cbp_back.sv
module cbp_back
    import cbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cbp_slot_t  head,
    output logic       pop,
    cbp_out_if.source  packed_out
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_end_reg;
    logic       load;
    logic       last;

    assign load = head.valid && (!out_valid_reg || packed_out.ready);
    assign last = (({1'b0, idx_reg} + 3'd1) == head.entry.count);
    assign pop  = load && last;

    assign packed_out.valid       = out_valid_reg;
    assign packed_out.out_byte    = out_byte_reg;
    assign packed_out.last_of_run = out_last_reg;
    assign packed_out.stream_end  = out_end_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (packed_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.entry.bytes[idx_reg];
            out_last_reg <= last;
            out_end_reg  <= last && head.entry.is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/code_bit_packer.sv
// channel   | role   | payload
// cfg       | sink   | code_width[5:0]
// codes     | sink   | command, code_value[31:0]
// packed_out| source | out_byte[7:0], last_of_run, stream_end
//
// one code yields 0 to 4 bytes, sent one byte per cycle from the output register
// while packed_out is ready; the byte sequencer sets this rate
// a code is classified and merged into the accumulator in the cycle it transfers
// a two-entry queue lets codes transfer while earlier bytes are still being sent
// reset empties the accumulator, the queue and the output register; code_width is 8

module code_bit_packer
    import cbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cbp_cfg_if.sink   cfg,
    cbp_in_if.sink    codes,
    cbp_out_if.source packed_out
);

    cbp_slot_t push;
    cbp_slot_t head;
    logic      push_ready;
    logic      pop;

    cbp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .codes      (codes),
        .push       (push),
        .push_ready (push_ready)
    );

    cbp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    cbp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .packed_out (packed_out)
    );

endmodule
